FILE: hw/rtl/ers_pkg.sv
// shared constants and types for the elevator request scheduler
// no dependencies
package ers_pkg;

  localparam int NUM_FLOORS = 64;
  localparam int FLOOR_W    = 6;
  localparam int CNT_W      = 7;

  localparam logic [1:0] DIR_UP     = 2'd0;
  localparam logic [1:0] DIR_DOWN   = 2'd1;
  localparam logic [1:0] DIR_EITHER = 2'd2;

  localparam logic [1:0] ACT_IDLE = 2'd0;
  localparam logic [1:0] ACT_UP   = 2'd1;
  localparam logic [1:0] ACT_DOWN = 2'd2;
  localparam logic [1:0] ACT_DOOR = 2'd3;

  localparam logic REQ_CALL = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_STEP,
    ST_DONE
  } state_t;

endpackage

FILE: hw/rtl/elevator_request_scheduler.sv
// elevator request scheduler top level: scan-style single-car scheduler
// depends on ers_pkg
//
// channel   dir   handshake              payload
// req       in    req_valid/req_ready    req_type, call_floor, req_dir
// rsp       out   rsp_valid/rsp_ready    accepted, action, car_floor, car_dir, pending_count
// cfg       in    cfg_we (no wait)       cfg_wdata (start floor preset)
//
// a floor request or a tick with nothing pending takes the sequencer from idle straight to
// the result step; any other tick first runs the target search, which passes over at most
// NUM_FLOORS - 1 floors, and then takes the car step before the result step
// one shared +/-1 unit walks the search pointer and then steps the car
// rst is synchronous: car at floor 0, nothing pending, direction either
// a result not yet taken holds the sequencer in its last step; req_ready is high only when idle
module elevator_request_scheduler (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      req_valid,
  output logic                      req_ready,
  input  logic                      req_type,
  input  logic [ers_pkg::FLOOR_W-1:0] call_floor,
  input  logic [1:0]                req_dir,
  output logic                      rsp_valid,
  input  logic                      rsp_ready,
  output logic                      accepted,
  output logic [1:0]                action,
  output logic [ers_pkg::FLOOR_W-1:0] car_floor,
  output logic [1:0]                car_dir,
  output logic [ers_pkg::CNT_W-1:0] pending_count,
  input  logic                      cfg_we,
  input  logic [ers_pkg::FLOOR_W-1:0] cfg_wdata
);
  import ers_pkg::*;

  // state
  state_t                 state, state_next;
  logic [FLOOR_W-1:0]     cur_floor;
  logic [NUM_FLOORS-1:0]  pending_map;
  logic [1:0]             travel_dir;
  logic [CNT_W-1:0]       pend_cnt;

  // sequencer working registers
  logic [FLOOR_W-1:0]     scan_idx;   // search pointer, holds the target once found
  logic                   scan_dn;    // search from the top for a downward car
  logic                   res_accepted;
  logic [1:0]             res_action;

  // control decodes
  logic                   req_fire;
  logic                   is_tick;
  logic                   map_empty;
  logic [1:0]             eff_dir;
  logic [1:0]             norm_dir;
  logic                   floor_ok;
  logic                   dir_ok;
  logic                   req_ok;
  logic                   scan_hit;
  logic                   out_free;
  logic                   load_out;

  // shared incrementer / decrementer and compare
  logic [FLOOR_W-1:0]     alu_in;
  logic                   alu_dn;
  logic [FLOOR_W-1:0]     alu_out;
  logic                   cur_lt_tgt;
  logic                   cur_gt_tgt;

  logic [FLOOR_W-1:0]     cfg_floor;

  assign map_empty = (pending_map == '0);
  assign eff_dir   = map_empty ? DIR_EITHER : travel_dir;
  assign req_fire  = req_valid && req_ready;
  assign is_tick   = (req_type == REQ_TICK);

  // direction code 3 behaves as either
  assign norm_dir = ((req_dir == DIR_UP) || (req_dir == DIR_DOWN)) ? req_dir : DIR_EITHER;

  // floors beyond the top are rejected
  assign floor_ok = ({1'b0, call_floor} < CNT_W'(NUM_FLOORS));

  // a moving car only takes requests in its own direction that are not behind it
  always_comb begin
    dir_ok = 1'b1;
    if (eff_dir == DIR_UP) begin
      dir_ok = (call_floor >= cur_floor) && (norm_dir == DIR_UP);
    end else if (eff_dir == DIR_DOWN) begin
      dir_ok = (call_floor <= cur_floor) && (norm_dir == DIR_DOWN);
    end
  end
  assign req_ok = floor_ok && dir_ok;

  assign scan_hit = pending_map[scan_idx];

  // target compare against the found floor
  assign cur_lt_tgt = (cur_floor < scan_idx);
  assign cur_gt_tgt = (cur_floor > scan_idx);

  // one +/-1 unit: walks the search pointer, then steps the car
  assign alu_in  = (state == ST_STEP) ? cur_floor : scan_idx;
  assign alu_dn  = (state == ST_STEP) ? cur_gt_tgt : scan_dn;
  assign alu_out = alu_dn ? (alu_in - FLOOR_W'(1)) : (alu_in + FLOOR_W'(1));

  // preset floor saturates at the top floor
  assign cfg_floor = ({1'b0, cfg_wdata} >= CNT_W'(NUM_FLOORS)) ?
                     FLOOR_W'(NUM_FLOORS - 1) : cfg_wdata;

  assign out_free = !rsp_valid || rsp_ready;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (req_fire) begin
          if (is_tick && !map_empty) begin
            state_next = ST_SCAN;
          end else begin
            state_next = ST_DONE;
          end
        end
      end
      ST_SCAN: begin
        if (scan_hit) begin
          state_next = ST_STEP;
        end
      end
      ST_STEP: begin
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // sequencer outputs
  always_comb begin
    req_ready = 1'b0;
    load_out  = 1'b0;
    unique case (state)
      ST_IDLE: req_ready = 1'b1;
      ST_SCAN: req_ready = 1'b0;
      ST_STEP: req_ready = 1'b0;
      ST_DONE: load_out  = out_free;
      default: req_ready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // scheduler state
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_floor   <= '0;
      pending_map <= '0;
      travel_dir  <= DIR_EITHER;
      pend_cnt    <= '0;
    end else begin
      if (cfg_we) begin
        cur_floor <= cfg_floor;
      end else if (state == ST_STEP && (cur_lt_tgt || cur_gt_tgt)) begin
        cur_floor <= alu_out;
      end
      if (req_fire && !is_tick && req_ok) begin
        // insert the request and take over its direction
        pending_map[call_floor] <= 1'b1;
        travel_dir              <= norm_dir;
        if (!pending_map[call_floor]) begin
          pend_cnt <= pend_cnt + CNT_W'(1);
        end
      end else if (state == ST_STEP && !cur_lt_tgt && !cur_gt_tgt) begin
        // doors open at the target, floor served
        pending_map[cur_floor] <= 1'b0;
        pend_cnt               <= pend_cnt - CNT_W'(1);
      end
    end
  end

  // search pointer and per-request result
  always_ff @(posedge clk) begin
    if (req_fire) begin
      scan_dn      <= (eff_dir == DIR_DOWN);
      scan_idx     <= (eff_dir == DIR_DOWN) ? FLOOR_W'(NUM_FLOORS - 1) : '0;
      res_accepted <= !is_tick && req_ok;
      res_action   <= ACT_IDLE;
    end else if (state == ST_SCAN && !scan_hit) begin
      scan_idx <= alu_out;
    end else if (state == ST_STEP) begin
      if (cur_lt_tgt) begin
        res_action <= ACT_UP;
      end else if (cur_gt_tgt) begin
        res_action <= ACT_DOWN;
      end else begin
        res_action <= ACT_DOOR;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (load_out) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      accepted      <= res_accepted;
      action        <= res_action;
      car_floor     <= cur_floor;
      car_dir       <= eff_dir;
      pending_count <= pend_cnt;
    end
  end

`ifndef SYNTHESIS
  // running count tracks the map
  a_cnt_matches_map: assert property (@(posedge clk) disable iff (rst)
    pend_cnt == CNT_W'($countones(pending_map)))
    else $error("pending count out of step with pending map");

  // the search only leaves on a pending floor
  a_step_on_pending: assert property (@(posedge clk) disable iff (rst)
    (state == ST_STEP) |-> pending_map[scan_idx])
    else $error("step entered without a pending target");

  // car moves up one floor toward a target above it
  a_move_up: assert property (@(posedge clk) disable iff (rst)
    (state == ST_STEP && cur_lt_tgt && !cfg_we) |=>
      (cur_floor == $past(cur_floor) + FLOOR_W'(1)))
    else $error("car did not move up by one floor");

  // an accepted request leaves the idle state
  a_busy_after_fire: assert property (@(posedge clk) disable iff (rst)
    req_fire |=> (state != ST_IDLE))
    else $error("sequencer idle right after a request");
`endif

endmodule
